### src/hrd_pkg.sv
// ----------------------------------------------------------------------------
// hrd_pkg
// shared types, item codes and helpers for the hid report descriptor parser
// ----------------------------------------------------------------------------
`default_nettype none

package hrd_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam int unsigned OUT_TDATA_W = 112;

  localparam logic [15:0] PAGE_RESET = 16'hffff;
  localparam logic [7:0]  KEY_MASK   = 8'hfc;
  localparam logic [1:0]  SIZE_FOUR  = 2'h3;

  // prefix with size bits cleared
  localparam logic [7:0] KEY_USAGE_PAGE = 8'h04;
  localparam logic [7:0] KEY_USAGE      = 8'h08;
  localparam logic [7:0] KEY_USAGE_MIN  = 8'h18;
  localparam logic [7:0] KEY_USAGE_MAX  = 8'h28;
  localparam logic [7:0] KEY_UNIT_EXP   = 8'h54;
  localparam logic [7:0] KEY_UNIT       = 8'h64;
  localparam logic [7:0] KEY_COLLECTION = 8'ha0;

  localparam logic [3:0] KIND_RESERVED = 4'd7;
  localparam logic [3:0] KIND_VENDOR   = 4'd8;
  localparam logic [3:0] NIB_VENDOR    = 4'hf;
  localparam logic [2:0] SYS_RESERVED  = 3'd5;
  localparam logic [2:0] SYS_VENDOR    = 3'd6;

  // one assembled item on its way from the front end to the decoder
  typedef struct packed {
    logic [7:0]  prefix;
    logic [31:0] data;
    logic        trunc;
    logic        restart;   // descriptor restarted since the previous item
  } hrd_item_t;

  function automatic logic [2:0] size_of(input logic [7:0] prefix);
    logic [2:0] sz;
    sz = (prefix[1:0] == SIZE_FOUR) ? 3'd4 : {1'b0, prefix[1:0]};
    return sz;
  endfunction

endpackage

`default_nettype wire

### src/hrd_front.sv
// ----------------------------------------------------------------------------
// hrd_front
// takes descriptor bytes, tracks prefix and data bytes, pushes finished items
// ----------------------------------------------------------------------------
`default_nettype none

module hrd_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              byte_valid_i,
  input  wire logic [7:0]        byte_i,
  input  wire logic              first_i,
  input  wire logic              last_i,
  output logic                   byte_ready_o,
  input  wire logic              q_full_i,
  output logic                   push_o,
  output hrd_pkg::hrd_item_t     push_item_o
);
  import hrd_pkg::*;

  logic [7:0]  prefix_q, prefix_d;
  logic [2:0]  left_q, left_d;
  logic [1:0]  idx_q, idx_d;
  logic [31:0] acc_q, acc_d;
  logic        restart_q, restart_d;

  logic        take;
  logic [2:0]  left_cur;
  logic [1:0]  idx_cur;
  logic [31:0] acc_cur;
  logic [31:0] acc_new;
  logic [2:0]  left_new;
  logic [2:0]  sz;

  assign byte_ready_o = !q_full_i;
  assign take         = byte_valid_i && !q_full_i;

  always_comb begin
    left_cur  = first_i ? 3'd0 : left_q;
    idx_cur   = first_i ? 2'd0 : idx_q;
    acc_cur   = first_i ? 32'd0 : acc_q;
    acc_new   = acc_cur | ({24'd0, byte_i} << {idx_cur, 3'b000});
    left_new  = left_cur - 3'd1;
    sz        = size_of(byte_i);

    prefix_d  = prefix_q;
    left_d    = left_q;
    idx_d     = idx_q;
    acc_d     = acc_q;
    restart_d = restart_q;
    push_o    = 1'b0;
    push_item_o = '{prefix: byte_i, data: 32'd0, trunc: 1'b0,
                    restart: restart_q || first_i};

    if (take) begin
      restart_d = restart_q || first_i;
      if (left_cur == 3'd0) begin
        // prefix byte
        if (sz == 3'd0) begin
          push_o = 1'b1;
          left_d = 3'd0;
          idx_d  = 2'd0;
          acc_d  = 32'd0;
        end else begin
          prefix_d = byte_i;
          idx_d    = 2'd0;
          acc_d    = 32'd0;
          if (last_i) begin
            left_d            = 3'd0;
            push_o            = 1'b1;
            push_item_o.trunc = 1'b1;
          end else begin
            left_d = sz;
          end
        end
      end else begin
        // data byte
        push_item_o.prefix = prefix_q;
        push_item_o.data   = acc_new;
        if (left_new == 3'd0) begin
          push_o = 1'b1;
          left_d = 3'd0;
          idx_d  = 2'd0;
          acc_d  = acc_new;
        end else if (last_i) begin
          push_o            = 1'b1;
          push_item_o.trunc = 1'b1;
          left_d            = 3'd0;
          idx_d             = 2'd0;
          acc_d             = acc_new;
        end else begin
          left_d = left_new;
          idx_d  = idx_cur + 2'd1;
          acc_d  = acc_new;
        end
      end
      if (push_o) begin
        restart_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q  <= 8'd0;
      left_q    <= 3'd0;
      idx_q     <= 2'd0;
      acc_q     <= 32'd0;
      restart_q <= 1'b0;
    end else begin
      prefix_q  <= prefix_d;
      left_q    <= left_d;
      idx_q     <= idx_d;
      acc_q     <= acc_d;
      restart_q <= restart_d;
    end
  end

endmodule

`default_nettype wire

### src/hrd_queue.sv
// ----------------------------------------------------------------------------
// hrd_queue
// short fifo of assembled items between byte front end and decoder
// ----------------------------------------------------------------------------
`default_nettype none

module hrd_queue #(
  parameter int unsigned DEPTH = hrd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  hrd_pkg::hrd_item_t      push_item_i,
  output logic                    full_o,
  input  wire logic               pop_i,
  output logic                    empty_o,
  output hrd_pkg::hrd_item_t      pop_item_o
);
  import hrd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  hrd_item_t        mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d;
  logic [PTR_W-1:0] rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o     = (cnt_q == CNT_FULL);
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_item_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_LAST) ? '0 : wr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_LAST) ? '0 : rd_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

### src/hrd_back.sv
// ----------------------------------------------------------------------------
// hrd_back
// decodes queued items, keeps the usage page, drives the result register
// ----------------------------------------------------------------------------
`default_nettype none

module hrd_back (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                q_empty_i,
  input  hrd_pkg::hrd_item_t                       q_item_i,
  output logic                                     pop_o,
  output logic                                     res_valid_o,
  input  wire logic                                res_ready_i,
  output logic [hrd_pkg::OUT_TDATA_W-1:0]          res_data_o
);
  import hrd_pkg::*;

  logic                   valid_q, valid_d;
  logic [OUT_TDATA_W-1:0] data_q, data_d;
  logic [15:0]            page_q, page_d;

  logic [7:0]  key;
  logic [31:0] dat;
  logic [15:0] page_cur;
  logic        usage;
  logic [31:0] full_usage;
  logic [3:0]  kind;
  logic [7:0]  expo;
  logic [2:0]  sys;
  logic [3:0]  nib;

  assign pop_o = !q_empty_i && (!valid_q || res_ready_i);

  always_comb begin
    key      = q_item_i.prefix & KEY_MASK;
    dat      = q_item_i.data;
    nib      = dat[3:0];
    page_cur = q_item_i.restart ? PAGE_RESET : page_q;
    page_d   = page_cur;
    if (key == KEY_USAGE_PAGE && !q_item_i.trunc) begin
      page_d = dat[15:0];
    end
    usage = (key == KEY_USAGE) || (key == KEY_USAGE_MIN) || (key == KEY_USAGE_MAX);
    full_usage = usage ? ({page_d, 16'd0} + dat) : 32'd0;

    kind = 4'd0;
    if (key == KEY_COLLECTION) begin
      if (dat <= 32'd6) begin
        kind = dat[3:0];
      end else if (dat[7]) begin
        kind = KIND_VENDOR;
      end else begin
        kind = KIND_RESERVED;
      end
    end

    expo = (key == KEY_UNIT_EXP) ? dat[7:0] : 8'd0;

    sys = 3'd0;
    if (key == KEY_UNIT) begin
      if (nib <= 4'd4) begin
        sys = nib[2:0];
      end else if (nib == NIB_VENDOR) begin
        sys = SYS_VENDOR;
      end else begin
        sys = SYS_RESERVED;
      end
    end

    data_d = {6'd0, q_item_i.trunc, sys, expo, kind, full_usage, usage, page_d, dat,
              size_of(q_item_i.prefix), q_item_i.prefix[7:4], q_item_i.prefix[3:2]};

    valid_d = valid_q;
    if (pop_o) begin
      valid_d = 1'b1;
    end else if (res_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      page_q  <= PAGE_RESET;
    end else begin
      valid_q <= valid_d;
      if (pop_o) begin
        page_q <= page_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= data_d;
    end
  end

  assign res_valid_o = valid_q;
  assign res_data_o  = data_q;

endmodule

`default_nettype wire

### src/hid_report_descriptor_item_parser_top.sv
// ----------------------------------------------------------------------------
// hid_report_descriptor_item_parser_top
// usb hid report descriptor short item parser, one descriptor byte per request
// ----------------------------------------------------------------------------
//  channel   direction  bits of tdata / tuser / tlast
//  s_axis    in         tdata[7:0] desc_byte, tuser first_byte, tlast last_byte
//  m_axis    out        tdata 112 bits, one decoded item per request
//
//  one descriptor byte is taken every cycle while the item queue has room
//  a completed item is written into the item queue when its last byte request
//  is accepted, then loaded into the decoder's output register, from which it
//  shows on m_axis
//  the usage page register in the decoder is the only loop across items
//  reset clears all control state; usage page resets to 0xffff, no clearing pass
//  an m_axis stall fills the queue, then s_axis_tready drops
// ----------------------------------------------------------------------------
`default_nettype none

module hid_report_descriptor_item_parser_top #(
  parameter int unsigned QUEUE_DEPTH = hrd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // byte requests
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [7:0]                   s_axis_tdata,   // [7:0] desc_byte
  input  wire logic                         s_axis_tuser,   // [0] first_byte
  input  wire logic                         s_axis_tlast,   // last_byte
  // item results
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // [1:0] item_type, [5:2] item_tag, [8:6] data_size, [40:9] item_data,
  // [56:41] usage_page, [57] is_usage, [89:58] full_usage,
  // [93:90] collection_kind, [101:94] unit_exponent, [104:102] unit_system,
  // [105] truncated, [111:106] zero
  output logic [hrd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import hrd_pkg::*;

  logic      push;
  hrd_item_t push_item;
  logic      q_full;
  logic      q_empty;
  logic      pop;
  hrd_item_t pop_item;

  // byte assembly: prefix, size countdown, little-endian data gather
  hrd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid),
    .byte_i       (s_axis_tdata),
    .first_i      (s_axis_tuser),
    .last_i       (s_axis_tlast),
    .byte_ready_o (s_axis_tready),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_item_o  (push_item)
  );

  // decouples the byte side from result stalls
  hrd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .pop_item_o  (pop_item)
  );

  // usage page tracking and field decode into the output register
  hrd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_item_i    (pop_item),
    .pop_o       (pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

### src/hrd_checker.sv
// ----------------------------------------------------------------------------
// hrd_checker
// port-level checks on the parser's result stream
// ----------------------------------------------------------------------------
`default_nettype none

module hrd_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         m_axis_tvalid,
  input wire logic                         m_axis_tready,
  input wire logic [hrd_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import hrd_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // pad bits stay zero
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[111:106] == 6'd0)
    else $error("pad bits set");

  // size is 0, 1, 2 or 4
  a_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[8:6] == 3'd0 || m_axis_tdata[8:6] == 3'd1 ||
                       m_axis_tdata[8:6] == 3'd2 || m_axis_tdata[8:6] == 3'd4))
    else $error("bad data size");

  // non-usage items carry no full usage
  a_usage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[57] |-> m_axis_tdata[89:58] == 32'd0)
    else $error("full usage on non-usage item");

  // only items with data can be cut short
  a_trunc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[105] |-> m_axis_tdata[8:6] != 3'd0)
    else $error("truncated zero-size item");

endmodule

bind hid_report_descriptor_item_parser_top hrd_checker u_hrd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
